[rtl/core/hvdma_pkg.sv]
package hvdma_pkg;

  // Item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_IDLE  = 2'd3;

  // IO register offsets
  localparam logic [6:0] REG_VBK   = 7'h4F;
  localparam logic [6:0] REG_HDMA1 = 7'h51;
  localparam logic [6:0] REG_HDMA4 = 7'h54;
  localparam logic [6:0] REG_HDMA5 = 7'h55;

  localparam logic [7:0] STATUS_IDLE = 8'hFF;
  localparam logic [7:0] STATUS_STOP = 8'h80;
  localparam logic [7:0] VBK_UNUSED  = 8'hFE;
  localparam logic [7:0] OPEN_BUS    = 8'hFF;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] reg_offset;
    logic [7:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [12:0] copy_dest;
    logic        copy_bank;
    logic [7:0]  copy_blocks;
  } out_item_t;

endpackage

[rtl/core/hvdma_engine.sv]
module hvdma_engine
  import hvdma_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  logic        color_model_r;
  logic [15:0] src_ptr_r, src_ptr_nxt;
  logic [12:0] dst_ptr_r, dst_ptr_nxt;
  logic [7:0]  blocks_left_r, blocks_left_nxt;
  logic        armed_r, armed_nxt;
  logic        bank_r, bank_nxt;
  logic [7:0]  addr_r [4];
  logic [7:0]  addr_nxt [4];
  logic [7:0]  status_r, status_nxt;

  logic [1:0]  idx;
  logic        is_addr;
  logic [15:0] start_src;
  logic [12:0] start_dst;
  logic [7:0]  start_blocks;
  logic [7:0]  blk_m1;

  // Block advance, shared by general transfers and hblank ticks
  logic        adv;
  logic [15:0] adv_src_base, adv_src;
  logic [12:0] adv_dst_base, adv_dst;
  logic [7:0]  adv_n, adv_blk_base, adv_blk;

  function automatic logic [1:0] reg_offset_idx(input logic [6:0] off);
    logic [6:0] d;
    d = off - REG_HDMA1;
    return d[1:0];
  endfunction

  assign idx          = reg_offset_idx(item.reg_offset);
  assign is_addr      = item.reg_offset inside {[REG_HDMA1:REG_HDMA4]};
  assign start_src    = {addr_r[0], addr_r[1][7:4], 4'h0};
  assign start_dst    = {addr_r[2][4:0], addr_r[3][7:4], 4'h0};
  assign start_blocks = {1'b0, item.wdata[6:0]} + 8'd1;
  assign blk_m1       = blocks_left_r - 8'd1;

  always_comb begin
    result          = '0;
    src_ptr_nxt     = src_ptr_r;
    dst_ptr_nxt     = dst_ptr_r;
    blocks_left_nxt = blocks_left_r;
    armed_nxt       = armed_r;
    bank_nxt        = bank_r;
    addr_nxt        = addr_r;
    status_nxt      = status_r;
    adv             = 1'b0;
    adv_src_base    = src_ptr_r;
    adv_dst_base    = dst_ptr_r;
    adv_n           = 8'd1;
    adv_blk_base    = blocks_left_r;

    case (item.mode)
      MODE_WRITE: begin
        if (item.reg_offset == REG_VBK) begin
          bank_nxt = color_model_r & item.wdata[0];
        end else if (is_addr) begin
          addr_nxt[idx] = item.wdata;
        end else if (item.reg_offset == REG_HDMA5) begin
          if (!color_model_r) begin
            status_nxt = STATUS_IDLE;
          end else if (armed_r && !item.wdata[7]) begin
            // cancel a running hblank transfer
            armed_nxt  = 1'b0;
            status_nxt = STATUS_STOP | {1'b0, blk_m1[6:0]};
          end else if (!item.wdata[7]) begin
            // general transfer: one command for all blocks
            adv                = 1'b1;
            adv_src_base       = start_src;
            adv_dst_base       = start_dst;
            adv_n              = start_blocks;
            adv_blk_base       = start_blocks;
            result.copy_valid  = 1'b1;
            result.copy_source = start_src;
            result.copy_dest   = start_dst;
            result.copy_bank   = bank_r;
            result.copy_blocks = start_blocks;
          end else begin
            src_ptr_nxt     = start_src;
            dst_ptr_nxt     = start_dst;
            blocks_left_nxt = start_blocks;
            armed_nxt       = 1'b1;
            status_nxt      = start_blocks - 8'd1;
          end
        end
      end
      MODE_READ: begin
        if (item.reg_offset == REG_VBK) begin
          result.rdata = VBK_UNUSED | {7'd0, bank_r};
        end else if (is_addr) begin
          result.rdata = addr_r[idx];
        end else if (item.reg_offset == REG_HDMA5) begin
          result.rdata = status_r;
        end else begin
          result.rdata = OPEN_BUS;
        end
      end
      MODE_TICK: begin
        if (color_model_r && armed_r) begin
          adv                = 1'b1;
          result.copy_valid  = 1'b1;
          result.copy_source = src_ptr_r;
          result.copy_dest   = dst_ptr_r;
          result.copy_bank   = bank_r;
          result.copy_blocks = 8'd1;
        end
      end
      default: begin
      end
    endcase

    adv_src = adv_src_base + {4'd0, adv_n, 4'h0};
    adv_dst = adv_dst_base + {1'b0, adv_n, 4'h0};
    adv_blk = (adv_blk_base >= adv_n) ? (adv_blk_base - adv_n) : 8'd0;

    if (adv) begin
      src_ptr_nxt     = adv_src;
      dst_ptr_nxt     = adv_dst;
      blocks_left_nxt = adv_blk;
      addr_nxt[0]     = adv_src[15:8];
      addr_nxt[1]     = {adv_src[7:4], 4'h0};
      addr_nxt[2]     = {3'd0, adv_dst[12:8]};
      addr_nxt[3]     = {adv_dst[7:4], 4'h0};
      if (adv_blk == 8'd0) begin
        armed_nxt  = 1'b0;
        status_nxt = STATUS_IDLE;
      end else begin
        status_nxt = adv_blk - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_model_r <= 1'b1;
      src_ptr_r     <= '0;
      dst_ptr_r     <= '0;
      blocks_left_r <= '0;
      armed_r       <= 1'b0;
      bank_r        <= 1'b0;
      addr_r        <= '{default: '0};
      status_r      <= STATUS_IDLE;
    end else begin
      if (cfg_we) begin
        color_model_r <= cfg_wdata;
      end
      if (fire) begin
        src_ptr_r     <= src_ptr_nxt;
        dst_ptr_r     <= dst_ptr_nxt;
        blocks_left_r <= blocks_left_nxt;
        armed_r       <= armed_nxt;
        bank_r        <= bank_nxt;
        addr_r        <= addr_nxt;
        status_r      <= status_nxt;
      end
    end
  end

endmodule

[rtl/core/hblank_vram_dma_controller.sv]
// Register front end of a VRAM DMA engine. Each input item is a register
// write, a register read or an hblank tick; every item yields exactly one
// result item carrying read data and/or a copy command for the byte mover.
//
// Channels: in_valid/in_ready/in_data and out_valid/out_ready/out_data,
// both valid/ready. cfg_we/cfg_wdata writes the color_model bit directly
// (no handshake); write it only while no item is in flight.
//
// An accepted item is held in the input register, and its result is then
// loaded into the output register, from which it can be taken. The block
// takes one item per cycle while out_ready stays high: the state update is
// a single pass of small adds between the input register and the output
// register.
//
// Reset (rst_n low, synchronous) empties both registers, clears all DMA
// state, sets status to 0xFF and color_model to 1.
// When out_ready is low the result holds in the output register, the
// next item waits in the input register, and in_ready drops once both
// are full.
module hblank_vram_dma_controller
  import hvdma_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      s1_adv;

  // Advance the held item when the output register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  hvdma_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (s1_adv),
    .item      (s1_data_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Load input payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold result while stalled
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/hvdma_checker.sv]
module hvdma_checker
  import hvdma_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Offered item waits unchanged until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item dropped or changed while waiting");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // No copy means zero command fields
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.copy_valid |->
      out_data.copy_source == 16'd0 && out_data.copy_dest == 13'd0 &&
      out_data.copy_bank == 1'b0 && out_data.copy_blocks == 8'd0)
    else $error("command fields set without a copy");

  // Copy carries 1..128 blocks and no read data
  a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.copy_valid |->
      out_data.copy_blocks != 8'd0 && out_data.copy_blocks <= 8'd128 &&
      out_data.rdata == 8'd0)
    else $error("bad copy command");

endmodule

bind hblank_vram_dma_controller hvdma_checker u_hvdma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
